### rtl/core/rsup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsup_pkg
// Operation codes, status codes and the stored record layout for the
// record stack core.
// ----------------------------------------------------------------------------
package rsup_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_UNIQUE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_DUP   = 2'd3;

  localparam int REC_W   = 208;
  localparam int COUNT_W = 5;

  // name sits in the lowest bits
  typedef struct packed {
    logic [7:0]  age;
    logic [7:0]  bred;
    logic [63:0] color;
    logic [63:0] kind;
    logic [63:0] name;
  } record_t;

endpackage
`default_nettype wire

### rtl/core/record_stack_unique_push_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_stack_unique_push_core
// Bounded LIFO of records with push, push-if-name-absent, pop and peek.
// ----------------------------------------------------------------------------
// One request is worked at a time. A unique push on a non-empty stack reads
// the stored names back one per cycle through the single read port of the
// record memory. A finished result sits in the output register while the
// next request is accepted. Stored records are undefined until pushed; no
// clearing pass is run after reset.
module record_stack_unique_push_core
  import rsup_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [207:0] s_tdata,   // name_key, kind_word, color_word, bred_flag, age_years
  input  logic [1:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [215:0] m_tdata,   // top_name, top_kind, top_color, top_bred, top_age,
                                  // entry_count, zero pad
  output logic [1:0]   m_tuser    // status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PEEK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] idx;
  record_t       req;
  logic [1:0]    res_status;
  record_t       res_top;

  record_t       mem [DEPTH];
  record_t       rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  record_t       wr_data;

  logic          s_accept;
  record_t       in_rec;
  logic          full;
  logic          empty;
  logic [AW-1:0] top_addr;
  logic          scan_last;
  logic          scan_hit;
  logic          pop_dec;
  logic [31:0]   count_ext;
  logic          emit_fire;

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign in_rec    = record_t'(s_tdata);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign top_addr  = AW'(count - CW'(1));
  assign scan_last = (idx == top_addr);
  assign scan_hit  = (rd_data.name == req.name);
  assign count_ext = 32'(count);
  assign emit_fire = (state == S_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    rd_addr = idx + AW'(1);
    if (state == S_IDLE) begin
      rd_addr = (s_tuser == OP_PEEK) ? top_addr : '0;
    end
  end

  assign wr_addr = AW'(count);
  assign wr_data = (state == S_IDLE) ? in_rec : req;
  assign pop_dec = s_accept && (s_tuser == OP_POP) && !empty;

  always_comb begin
    wr_en = 1'b0;
    if (s_accept && (s_tuser == OP_PUSH) && !full) begin
      wr_en = 1'b1;
    end
    if (s_accept && (s_tuser == OP_UNIQUE) && empty) begin
      wr_en = 1'b1;
    end
    if ((state == S_SCAN) && !scan_hit && scan_last && !full) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    count_next = count;
    if (wr_en) begin
      count_next = count + CW'(1);
    end else if (pop_dec) begin
      count_next = count - CW'(1);
    end
  end

  // record memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            req     <= in_rec;
            idx     <= '0;
            res_top <= '0;
            case (s_tuser)
              OP_PUSH: begin
                res_status <= full ? ST_FULL : ST_OK;
                state      <= S_EMIT;
              end
              OP_UNIQUE: begin
                res_status <= ST_OK;
                state      <= empty ? S_EMIT : S_SCAN;
              end
              OP_POP: begin
                res_status <= empty ? ST_EMPTY : ST_OK;
                state      <= S_EMIT;
              end
              OP_PEEK: begin
                res_status <= empty ? ST_EMPTY : ST_OK;
                state      <= empty ? S_EMIT : S_PEEK;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            res_status <= ST_DUP;
            state      <= S_EMIT;
          end else if (scan_last) begin
            if (full) begin
              res_status <= ST_FULL;
            end
            state <= S_EMIT;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_PEEK: begin
          res_top <= rd_data;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            m_tdata <= {3'b000, count_ext[COUNT_W-1:0], res_top};
            m_tuser <= res_status;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(idx) < count))
    else $error("scan index beyond held entries");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (s_tuser == OP_POP) && !empty) |=> (count == $past(count) - CW'(1)))
    else $error("pop did not drop the count");

  a_zero_top: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[REC_W-1:0] == '0))
    else $error("top fields set on a failed request");
`endif

endmodule
`default_nettype wire

### tb/sv/record_stack_unique_push_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_stack_unique_push_core_tb
// Self-checking bench for the record stack. A short directed table hits
// the empty, full and duplicate-name corners. Random traffic then follows,
// moving between fill, drain and mixed phases. Names reuse a small pool or
// the stack, so duplicate checks fire often. Every request's response is
// predicted and compared field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module record_stack_unique_push_core_tb;
  import rsup_pkg::*;

  localparam int DEPTH      = 16;
  localparam int N_RANDOM   = 1700;
  localparam int CYCLE_MAX  = 400000;
  localparam int TAIL_WAIT  = 40;

  typedef struct packed {
    logic [1:0]         status;
    record_t            top;
    logic [COUNT_W-1:0] count;
  } stack_result_t;

  typedef struct {
    logic [1:0]    func;
    record_t       rec;
    bit            checked;
    stack_result_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [207:0] s_tdata = '0;   // name_key, kind_word, color_word, bred_flag, age_years
  logic [1:0]   s_tuser = '0;   // func
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [215:0] m_tdata;        // top_name, top_kind, top_color, top_bred, top_age,
                                // entry_count, zero pad
  logic [1:0]   m_tuser;        // status

  record_stack_unique_push_core #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  record_t         stack_mem [DEPTH];
  int unsigned     stack_fill = 0;
  stack_result_t   pending_results [$];
  dir_row_t        dir_rows [$];
  logic [63:0]     name_pool [6];
  int              err_cnt = 0;
  int              cycle_cnt = 0;
  int              burst_left = 1;
  int              phase_left = 0;
  int              phase_mode = 0;
  int              rdy_left = 0;
  int              rdy_mode = 0;
  int unsigned     rdy_cnt = 0;

  function automatic stack_result_t stack_step(input logic [1:0] func, input record_t rec);
    stack_result_t r;
    bit            dup;
    r   = '0;
    dup = 1'b0;
    case (func)
      OP_PUSH, OP_UNIQUE: begin
        if (func == OP_UNIQUE)
          for (int i = 0; i < stack_fill; i++)
            if (stack_mem[i].name == rec.name) dup = 1'b1;
        if (dup) r.status = ST_DUP;
        else if (stack_fill >= DEPTH) r.status = ST_FULL;
        else begin
          stack_mem[stack_fill] = rec;
          stack_fill++;
          r.status = ST_OK;
        end
      end
      OP_POP: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else stack_fill--;
      end
      default: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else r.top = stack_mem[stack_fill - 1];
      end
    endcase
    r.count = stack_fill[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic record_t rand_record(input logic [63:0] name);
    record_t rec;
    rec.name  = name;
    rec.kind  = ($urandom_range(0, 19) == 0) ? {64{1'b1}} : rand64();
    rec.color = ($urandom_range(0, 19) == 0) ? '0 : rand64();
    rec.bred  = 8'($urandom_range(0, 255));
    rec.age   = 8'($urandom_range(0, 255));
    return rec;
  endfunction

  function automatic void add_row(input logic [1:0] func, input record_t rec,
                                  input bit checked, input stack_result_t want);
    dir_row_t row;
    row.func    = func;
    row.rec     = rec;
    row.checked = checked;
    row.want    = want;
    dir_rows.push_back(row);
  endfunction

  function automatic stack_result_t res(input logic [1:0] status, input record_t top,
                                        input int count);
    stack_result_t r;
    r.status = status;
    r.top    = top;
    r.count  = count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_req(input logic [1:0] func, input record_t rec,
                          input bit checked, input stack_result_t want);
    stack_result_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= rec;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = stack_step(func, rec);
    pending_results.push_back(checked ? want : r);
  endtask

  // hold: drop valid and wait until every response is back
  task automatic pace(input bit hold);
    if (burst_left > 0) burst_left--;
    if (hold || burst_left == 0) begin
      s_tvalid <= 1'b0;
      if (hold) begin
        do @(posedge clk); while (pending_results.size() != 0);
      end else begin
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
    end
  endtask

  task automatic gen_random(output logic [1:0] func, output record_t rec);
    int          pick;
    logic [63:0] name;
    if (phase_left == 0) begin
      phase_mode = $urandom_range(0, 2);
      phase_left = $urandom_range(10, 60);
    end
    phase_left--;
    pick = $urandom_range(0, 99);
    case (phase_mode)
      0:       func = (pick < 35) ? OP_PUSH : (pick < 80) ? OP_UNIQUE :
                      (pick < 90) ? OP_POP : OP_PEEK;
      1:       func = (pick < 10) ? OP_PUSH : (pick < 25) ? OP_UNIQUE :
                      (pick < 85) ? OP_POP : OP_PEEK;
      default: func = pick[1:0];
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 4 || (pick < 7 && stack_fill == 0))
      name = name_pool[$urandom_range(0, 5)];
    else if (pick < 7)
      name = stack_mem[$urandom_range(0, stack_fill - 1)].name;
    else
      name = rand64();
    rec = rand_record(name);
  endtask

  // response checker
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request pending: status %0d", m_tuser);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          err_cnt++;
        end
        if (m_tdata[63:0] != want.top.name) begin
          $error("top_name: expected %h, got %h", want.top.name, m_tdata[63:0]);
          err_cnt++;
        end
        if (m_tdata[127:64] != want.top.kind) begin
          $error("top_kind: expected %h, got %h", want.top.kind, m_tdata[127:64]);
          err_cnt++;
        end
        if (m_tdata[191:128] != want.top.color) begin
          $error("top_color: expected %h, got %h", want.top.color, m_tdata[191:128]);
          err_cnt++;
        end
        if (m_tdata[199:192] != want.top.bred) begin
          $error("top_bred: expected %h, got %h", want.top.bred, m_tdata[199:192]);
          err_cnt++;
        end
        if (m_tdata[207:200] != want.top.age) begin
          $error("top_age: expected %h, got %h", want.top.age, m_tdata[207:200]);
          err_cnt++;
        end
        if (m_tdata[212:208] != want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, m_tdata[212:208]);
          err_cnt++;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 3);
      rdy_left <= $urandom_range(8, 64);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rdy_cnt[1:0] != 2'd0);
    endcase
    rdy_cnt <= rdy_cnt + 1;
  end

  initial begin
    while (cycle_cnt < CYCLE_MAX) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    record_t       ones;
    record_t       zero;
    record_t       rec;
    logic [1:0]    func;
    stack_result_t none;

    ones = '1;
    zero = '0;
    none = '0;
    foreach (name_pool[i]) name_pool[i] = rand64();
    name_pool[0] = '0;

    add_row(OP_PEEK,   rand_record(rand64()), 1'b1, res(ST_EMPTY, zero, 0));
    add_row(OP_POP,    rand_record(rand64()), 1'b1, res(ST_EMPTY, zero, 0));
    add_row(OP_PUSH,   ones,                  1'b1, res(ST_OK,    zero, 1));
    add_row(OP_PEEK,   zero,                  1'b1, res(ST_OK,    ones, 1));
    add_row(OP_UNIQUE, ones,                  1'b1, res(ST_DUP,   zero, 1));
    add_row(OP_UNIQUE, rand_record('0),       1'b0, none);
    add_row(OP_PUSH,   zero,                  1'b1, res(ST_OK,    zero, 3));
    add_row(OP_PEEK,   ones,                  1'b1, res(ST_OK,    zero, 3));
    add_row(OP_POP,    ones,                  1'b1, res(ST_OK,    zero, 2));
    // fill up with distinct names, scan grows each time
    for (int i = 0; i < DEPTH - 2; i++)
      add_row(OP_UNIQUE, rand_record(rand64()), 1'b0, none);
    add_row(OP_PUSH,   rand_record(rand64()), 1'b1, res(ST_FULL, zero, DEPTH));
    // duplicate wins over full
    add_row(OP_UNIQUE, ones,                  1'b1, res(ST_DUP,  zero, DEPTH));
    add_row(OP_UNIQUE, rand_record(rand64()), 1'b0, none);
    add_row(OP_PEEK,   rand_record(rand64()), 1'b0, none);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].func, dir_rows[i].rec, dir_rows[i].checked, dir_rows[i].want);
      pace(i == dir_rows.size() - 1);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      gen_random(func, rec);
      send_req(func, rec, 1'b0, none);
      pace(n == N_RANDOM / 2 || n == N_RANDOM - 1);
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### record_stack_unique_push_core.f
rtl/core/rsup_pkg.sv
rtl/core/record_stack_unique_push_core.sv
tb/sv/record_stack_unique_push_core_tb.sv
